// ===== rtl/tst_pkg.sv =====
// Timer slot table package: request, response and command types, codes and sizes.
// Used by every module of the timer slot table and by its checker.
`timescale 1ns / 1ps
package tst_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int MAX_RESULTS = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int REMOVED_W  = $clog2(SLOT_COUNT + 1);
   localparam int FIRE_CNT_W = $clog2(MAX_RESULTS + 1);
   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   // request opcodes
   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_SCHEDULE   = 2'd1;
   localparam logic [1:0] OP_UNSCHEDULE = 2'd2;

   // response event kinds
   localparam logic [2:0] EV_FIRED       = 3'd0;
   localparam logic [2:0] EV_NOTHING_DUE = 3'd1;
   localparam logic [2:0] EV_SCHEDULED   = 3'd2;
   localparam logic [2:0] EV_TABLE_FULL  = 3'd3;
   localparam logic [2:0] EV_UNSCHEDULED = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [30:0] delay_ms;
      logic        one_shot;
      logic [15:0] handler_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [4:0]  slot_index;
      logic [15:0] fired_handler;
      logic [5:0]  removed_count;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_SCHEDULE,
      CMD_UNSCHEDULE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  now_ms;
      logic [30:0]  delay_ms;
      logic         one_shot;
      logic [15:0]  handler_id;
   } cmd_type;

   // front to queue
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } scan_state_type;

endpackage

// ===== rtl/tst_front.sv =====
// Front end: accepts requests, decodes the opcode and drops unused codes.
// Depends on tst_pkg; feeds tst_queue.
`timescale 1ns / 1ps
module tst_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tst_pkg::req_type      req_data,
   input  logic                  q_full,
   output tst_pkg::cmd_push_type push
);
   import tst_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;
   logic    push_done;

   // hold the decoded request while the queue is full
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push_done = valid_ff && !q_full;

   assign push.valid = valid_ff;
   assign push.cmd   = cmd_ff;

   // decode opcode, drop the unused code
   always_comb begin
      valid_in           = valid_ff && !push_done;
      cmd_in             = cmd_ff;
      if (accept) begin
         cmd_in.now_ms     = req_data.now_ms;
         cmd_in.delay_ms   = req_data.delay_ms;
         cmd_in.one_shot   = req_data.one_shot;
         cmd_in.handler_id = req_data.handler_id;
         unique case (req_data.opcode)
            OP_TICK: begin
               cmd_in.kind = CMD_TICK;
               valid_in    = 1'b1;
            end
            OP_SCHEDULE: begin
               cmd_in.kind = CMD_SCHEDULE;
               valid_in    = 1'b1;
            end
            OP_UNSCHEDULE: begin
               cmd_in.kind = CMD_UNSCHEDULE;
               valid_in    = 1'b1;
            end
            default: begin
               valid_in    = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ===== rtl/tst_queue.sv =====
// Short command queue between the front end and the scan engine.
// Depends on tst_pkg; written by tst_front, read by tst_back.
`timescale 1ns / 1ps
module tst_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tst_pkg::cmd_push_type push,
   output logic                  q_full,
   output tst_pkg::cmd_head_type head,
   input  logic                  pop
);
   import tst_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !q_full;
   assign do_pop  = pop && head.valid;

   // advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== rtl/tst_back.sv =====
// Scan engine: holds the slot table, walks it one slot a cycle per command while the output
// is free, and drives the response register. Depends on tst_pkg; fed by tst_queue.
`timescale 1ns / 1ps
module tst_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tst_pkg::cmd_head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tst_pkg::rsp_type      rsp_data
);
   import tst_pkg::*;

   // slot table
   logic [31:0] due_ff    [SLOT_COUNT];
   logic        once_ff   [SLOT_COUNT];
   logic [31:0] period_ff [SLOT_COUNT];
   logic [15:0] tag_ff    [SLOT_COUNT];

   scan_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic [FIRE_CNT_W-1:0] fired_ff, fired_in;
   logic [REMOVED_W-1:0]  removed_ff, removed_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_type               pend_ff, pend_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   // slot write controls
   logic        due_we, slot_we;
   logic [31:0] due_wdata;

   logic [31:0] cur_due;
   logic [15:0] cur_tag;
   logic        out_free;
   logic        last_slot;
   logic        fire_hit;

   assign cur_due   = due_ff[idx_ff];
   assign cur_tag   = tag_ff[idx_ff];
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign last_slot = (idx_ff == SLOT_IDX_W'(SLOT_COUNT - 1));
   assign fire_hit  = (cur_due != '0) && (cur_due <= cmd_ff.now_ms);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // sequence the scan and build responses
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      fired_in      = fired_ff;
      removed_in    = removed_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;
      pop           = 1'b0;
      due_we        = 1'b0;
      slot_we       = 1'b0;
      due_wdata     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop           = 1'b1;
               cmd_in        = head.cmd;
               idx_in        = '0;
               fired_in      = '0;
               removed_in    = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (last_slot) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
               unique case (cmd_ff.kind)
                  CMD_TICK: begin
                     if (fire_hit) begin
                        due_we    = 1'b1;
                        due_wdata = once_ff[idx_ff] ? '0 : cmd_ff.now_ms + period_ff[idx_ff];
                        if (fired_ff < FIRE_CNT_W'(MAX_RESULTS)) begin
                           fired_in = fired_ff + 1'b1;
                           // release the earlier firing, keep this one back
                           if (pend_valid_ff) begin
                              out_valid_in = 1'b1;
                              out_in       = pend_ff;
                           end
                           pend_valid_in         = 1'b1;
                           pend_in.event_kind    = EV_FIRED;
                           pend_in.slot_index    = 5'(idx_ff);
                           pend_in.fired_handler = cur_tag;
                           pend_in.removed_count = '0;
                           pend_in.last_of_run   = 1'b0;
                        end
                     end
                  end
                  CMD_SCHEDULE: begin
                     if (cur_due == '0) begin
                        due_we               = 1'b1;
                        slot_we              = 1'b1;
                        due_wdata            = cmd_ff.now_ms + {1'b0, cmd_ff.delay_ms};
                        out_valid_in         = 1'b1;
                        out_in.event_kind    = EV_SCHEDULED;
                        out_in.slot_index    = 5'(idx_ff);
                        out_in.fired_handler = cmd_ff.handler_id;
                        out_in.removed_count = '0;
                        out_in.last_of_run   = 1'b1;
                        state_in             = ST_IDLE;
                     end
                  end
                  CMD_UNSCHEDULE: begin
                     if ((cur_due != '0) && (cur_tag == cmd_ff.handler_id)) begin
                        due_we     = 1'b1;
                        due_wdata  = '0;
                        removed_in = removed_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_in.slot_index    = '0;
               out_in.fired_handler = '0;
               out_in.removed_count = '0;
               out_in.last_of_run   = 1'b1;
               unique case (cmd_ff.kind)
                  CMD_TICK: begin
                     if (pend_valid_ff) begin
                        out_in             = pend_ff;
                        out_in.last_of_run = 1'b1;
                     end else begin
                        out_in.event_kind = EV_NOTHING_DUE;
                     end
                  end
                  CMD_SCHEDULE: begin
                     out_in.event_kind = EV_TABLE_FULL;
                  end
                  CMD_UNSCHEDULE: begin
                     out_in.event_kind    = EV_UNSCHEDULED;
                     out_in.removed_count = 6'(removed_ff);
                  end
                  default: begin
                     out_in.event_kind = EV_NOTHING_DUE;
                  end
               endcase
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      fired_ff   <= fired_in;
      removed_ff <= removed_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   // slot table: due time and one-shot mark clear at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            due_ff[s]  <= '0;
            once_ff[s] <= 1'b0;
         end
      end else begin
         if (due_we) begin
            due_ff[idx_ff] <= due_wdata;
         end
         if (slot_we) begin
            once_ff[idx_ff] <= cmd_ff.one_shot;
         end
      end
      if (slot_we) begin
         period_ff[idx_ff] <= cmd_ff.one_shot ? '0 : {1'b0, cmd_ff.delay_ms};
         tag_ff[idx_ff]    <= cmd_ff.handler_id;
      end
   end

endmodule

// ===== rtl/timer_slot_table_top.sv =====
// Timer slot table, top level: SLOT_COUNT slots scanned one a cycle per request while the
// response register is free. For a tick or unschedule the scan engine pops the request,
// scans every slot and closes with a final response; a schedule ends at the first free
// slot. The scan engine takes no new request until the last one is done; response stalls
// hold the scan. Reset (synchronous) frees every slot.
`timescale 1ns / 1ps
module timer_slot_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tst_pkg::rsp_type rsp_data
);
   import tst_pkg::*;

   cmd_push_type push;
   cmd_head_type head;
   logic         q_full;
   logic         pop;

   tst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   tst_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .q_full (q_full),
      .head   (head),
      .pop    (pop)
   );

   tst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/tst_checker.sv =====
// Port-level checker for the timer slot table, bound to the top level.
// Depends on tst_pkg.
`timescale 1ns / 1ps
module tst_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tst_pkg::rsp_type rsp_data
);
   import tst_pkg::*;

   // no response and no request stall straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("handshake busy after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // only firings may be followed by more responses of the same request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind != EV_FIRED) |-> rsp_data.last_of_run)
      else $error("non-fired response without last_of_run");

   // unschedule carries a count within the table size and no handler
   a_unsched_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == EV_UNSCHEDULED)
      |-> (rsp_data.removed_count <= 6'(SLOT_COUNT)) && (rsp_data.fired_handler == '0))
      else $error("bad unscheduled response");

   // a fired slot lies inside the table and carries no removed count
   a_fired_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_kind == EV_FIRED)
      |-> (rsp_data.slot_index < 5'(SLOT_COUNT)) && (rsp_data.removed_count == '0))
      else $error("bad fired response");

endmodule

bind timer_slot_table_top tst_checker u_tst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/tst_result_checker.sv =====
// Result checker for the timer slot table: watches both channels, keeps its own copy
// of the slot table and compares every accepted response with the predicted one.
// Depends on tst_pkg for the request and response types and the code constants.
`timescale 1ns / 1ps
module tst_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  tst_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tst_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               request_count,
   output int               result_count,
   output int               fired_count,
   output int               full_count
);
   import tst_pkg::*;

   // shadow copy of the slot table
   logic [31:0] slot_due    [SLOT_COUNT];
   logic [31:0] slot_period [SLOT_COUNT];
   logic        slot_once   [SLOT_COUNT];
   logic [15:0] slot_tag    [SLOT_COUNT];

   // responses predicted but not yet seen, oldest first
   rsp_type awaited_events[$];

   // Work out the responses of one request and update the shadow table.
   task automatic predict_slot_events(input req_type r);
      rsp_type    batch [MAX_RESULTS];
      rsp_type    ev;
      int         n;
      bit         placed;
      logic [5:0] removed;
      n       = 0;
      placed  = 1'b0;
      removed = '0;
      ev      = '0;
      case (r.opcode)
         OP_TICK: begin
            // fire every used slot that is due, in slot order
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (slot_due[s] != 32'd0 && slot_due[s] <= r.now_ms) begin
                  slot_due[s] = slot_once[s] ? 32'd0 : r.now_ms + slot_period[s];
                  if (n < MAX_RESULTS) begin
                     batch[n]               = '0;
                     batch[n].event_kind    = EV_FIRED;
                     batch[n].slot_index    = 5'(s);
                     batch[n].fired_handler = slot_tag[s];
                     n++;
                  end
               end
            end
            if (n == 0) begin
               ev.event_kind  = EV_NOTHING_DUE;
               ev.last_of_run = 1'b1;
               awaited_events.push_back(ev);
            end else begin
               batch[n-1].last_of_run = 1'b1;
               for (int k = 0; k < n; k++) awaited_events.push_back(batch[k]);
            end
         end
         OP_SCHEDULE: begin
            // fill the lowest free slot; a due time that wraps to zero leaves it free
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (!placed && slot_due[s] == 32'd0) begin
                  slot_period[s]   = r.one_shot ? 32'd0 : {1'b0, r.delay_ms};
                  slot_due[s]      = r.now_ms + {1'b0, r.delay_ms};
                  slot_once[s]     = r.one_shot;
                  slot_tag[s]      = r.handler_id;
                  ev.event_kind    = EV_SCHEDULED;
                  ev.slot_index    = 5'(s);
                  ev.fired_handler = r.handler_id;
                  placed           = 1'b1;
               end
            end
            if (!placed) ev.event_kind = EV_TABLE_FULL;
            ev.last_of_run = 1'b1;
            awaited_events.push_back(ev);
         end
         OP_UNSCHEDULE: begin
            // free every used slot carrying this handler
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (slot_due[s] != 32'd0 && slot_tag[s] == r.handler_id) begin
                  slot_due[s] = 32'd0;
                  removed++;
               end
            end
            ev.event_kind    = EV_UNSCHEDULED;
            ev.removed_count = removed;
            ev.last_of_run   = 1'b1;
            awaited_events.push_back(ev);
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got, inout bit bad);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
                  want, got);
         bad = 1'b1;
      end
   endtask

   // Take requests first, then check the response accepted on the same edge.
   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_due[s]  = 32'd0;
            slot_once[s] = 1'b0;
         end
         awaited_events.delete();
         fail_count    = 0;
         request_count = 0;
         result_count  = 0;
         fired_count   = 0;
         full_count    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_slot_events(req_data);
            request_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (rsp_data.event_kind == EV_FIRED)      fired_count++;
            if (rsp_data.event_kind == EV_TABLE_FULL) full_count++;
            if (awaited_events.size() == 0) begin
               $display("%0t ns: response with none expected, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = awaited_events.pop_front();
               bad  = 1'b0;
               compare_field("event_kind", 32'(want.event_kind),
                             32'(rsp_data.event_kind), bad);
               compare_field("slot_index", 32'(want.slot_index),
                             32'(rsp_data.slot_index), bad);
               compare_field("fired_handler", 32'(want.fired_handler),
                             32'(rsp_data.fired_handler), bad);
               compare_field("removed_count", 32'(want.removed_count),
                             32'(rsp_data.removed_count), bad);
               compare_field("last_of_run", 32'(want.last_of_run),
                             32'(rsp_data.last_of_run), bad);
               if (bad) fail_count++;
            end
         end
      end
      pending_count = awaited_events.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the timer slot table: clock, reset, request and stall stimulus,
// watchdog and verdict. Depends on tst_pkg, timer_slot_table_top and tst_result_checker.
`timescale 1ns / 1ps
module tb_top;
   import tst_pkg::*;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         RANDOM_ITEMS   = 160;
   localparam int         CALM_ITEMS     = 30;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         DRAIN_CYCLES   = 4 * (SLOT_COUNT + 2);

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit calm       = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   int fail_count, pending_count, request_count, result_count, fired_count, full_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   timer_slot_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tst_result_checker slot_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .request_count (request_count),
      .result_count  (result_count),
      .fired_count   (fired_count),
      .full_count    (full_count)
   );

   // Stall the response channel in random bursts, except in the calm phase.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Abort when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("timer_slot_table_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [1:0] op, input logic [31:0] now,
                                        input logic [30:0] delay, input logic once,
                                        input logic [15:0] hid);
      req_type r;
      r.opcode     = op;
      r.now_ms     = now;
      r.delay_ms   = delay;
      r.one_shot   = once;
      r.handler_id = hid;
      return r;
   endfunction

   // Present one request from a falling edge and hold it until accepted.
   task automatic send_req(input req_type item);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_handler();
      return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
   endfunction

   initial begin
      logic [31:0] sim_ms;
      logic [31:0] now;
      logic [30:0] delay;
      int          taken;
      int          pick;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, unused opcode
      send_req(make_req(OP_TICK, 32'd0, 31'd0, 1'b0, 16'h0000));
      send_req(make_req(OP_UNSCHEDULE, 32'd0, 31'd0, 1'b0, 16'h0000));
      send_req(make_req(OP_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 16'hFFFF));
      // fill the table, including a due time that wraps to zero and stays free
      send_req(make_req(OP_SCHEDULE, 32'd10, 31'd5, 1'b1, 16'h0000));
      send_req(make_req(OP_SCHEDULE, 32'd10, 31'h7FFF_FFFF, 1'b0, 16'hFFFF));
      send_req(make_req(OP_SCHEDULE, 32'h8000_0001, 31'h7FFF_FFFF, 1'b1, 16'h1234));
      send_req(make_req(OP_SCHEDULE, 32'd10, 31'd0, 1'b0, 16'hAAAA));
      send_req(make_req(OP_SCHEDULE, 32'd20, 31'd3, 1'b0, 16'h5555));
      send_req(make_req(OP_SCHEDULE, 32'd20, 31'd3, 1'b0, 16'h5555));
      send_req(make_req(OP_SCHEDULE, 32'd0, 31'd0, 1'b1, 16'h0007));
      send_req(make_req(OP_SCHEDULE, 32'd30, 31'd40, 1'b1, 16'h0007));
      send_req(make_req(OP_SCHEDULE, 32'd30, 31'd50, 1'b0, 16'h0008));
      send_req(make_req(OP_SCHEDULE, 32'hFFFF_FF00, 31'd16, 1'b0, 16'h0009));
      send_req(make_req(OP_SCHEDULE, 32'd40, 31'd1, 1'b0, 16'h00FF));
      // every slot fires; periodic reloads wrap, one of them to zero
      send_req(make_req(OP_TICK, 32'hFFFF_FFF0, 31'd0, 1'b0, 16'h0000));
      send_req(make_req(OP_TICK, 32'hFFFF_FFF1, 31'd0, 1'b0, 16'h0000));
      send_req(make_req(OP_UNSCHEDULE, 32'd0, 31'd0, 1'b0, 16'h5555));
      send_req(make_req(OP_UNSCHEDULE, 32'd0, 31'd0, 1'b0, 16'hAAAA));
      send_req(make_req(OP_TICK, 32'hFFFF_FFFF, 31'd0, 1'b0, 16'h0000));
      send_req(make_req(OP_TICK, 32'd5, 31'd0, 1'b0, 16'h0000));
      send_req(make_req(OP_UNSCHEDULE, 32'd0, 31'd0, 1'b0, 16'hFFFF));
      send_req(make_req(OP_UNSCHEDULE, 32'd0, 31'd0, 1'b0, 16'h0008));
      send_req(make_req(OP_UNSCHEDULE, 32'd0, 31'd0, 1'b0, 16'h0009));

      // random: mostly a running clock with small delays and a small handler set
      sim_ms = $urandom;
      taken  = 0;
      while (taken < RANDOM_ITEMS) begin
         calm   = (taken >= RANDOM_ITEMS - CALM_ITEMS);
         sim_ms = sim_ms + $urandom_range(0, 12);
         now    = ($urandom_range(0, 19) == 0) ? $urandom : sim_ms;
         delay  = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 30));
         pick   = $urandom_range(0, 99);
         if (pick < 5) begin
            send_req(make_req(OP_UNUSED, $urandom, 31'($urandom), 1'($urandom),
                              16'($urandom)));
         end else begin
            if (pick < 40)
               send_req(make_req(OP_TICK, now, 31'($urandom), 1'($urandom),
                                 16'($urandom)));
            else if (pick < 78)
               send_req(make_req(OP_SCHEDULE, now, delay, 1'($urandom_range(0, 1)),
                                 pick_handler()));
            else
               send_req(make_req(OP_UNSCHEDULE, now, 31'($urandom), 1'($urandom),
                                 pick_handler()));
            taken++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then watch for stray ones
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (pending_count != 0)
         $display("%0t ns: %0d expected responses never arrived", $time, pending_count);
      $display("Run covered %0d requests and %0d responses (%0d firings, %0d table full).",
               request_count, result_count, fired_count, full_count);
      $display("Mismatches and stray responses: %0d", fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("timer_slot_table_top verification clean");
      end else begin
         $display("timer_slot_table_top verification failed");
      end
      $finish;
   end

endmodule
